// File: hw/rtl/sht_pkg.sv
// Package for the shape hit test block: coordinate widths, shape kinds,
// the item structs and small arithmetic helpers shared by all modules.
// No dependencies.
package sht_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int NUM_COORDS  = 10;
  localparam int TDATA_W     = ((NUM_COORDS * COORD_WIDTH + 7) / 8) * 8;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int EDGE_W      = PROD_W + 2;
  localparam int OUT_TDATA_W = 8;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [EDGE_W-1:0]      edge_t;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_TRI   = 2'd2,
    KIND_RECT  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t  kind;
    coord_t vx0;
    coord_t vy0;
    coord_t vx1;
    coord_t vy1;
    coord_t vx2;
    coord_t vy2;
    coord_t vx3;
    coord_t vy3;
    coord_t click_x;
    coord_t click_y;
    logic   last_shape;
  } shape_t;

  typedef struct packed {
    logic hit;
    logic bad_kind;
    logic last_result;
  } result_t;

  function automatic diff_t sdiff(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  function automatic prod_t smul(diff_t a, diff_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  function automatic coord_t cmin(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic coord_t cmax(coord_t a, coord_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: hw/rtl/sht_eval.sv
// Combinational hit test of one shape against its click position.
// Depends on sht_pkg for the shape and result structs and the helpers.
module sht_eval (
  input  sht_pkg::shape_t  shape_i,
  output sht_pkg::result_t result_o
);

  always_comb begin
    logic           seg_box;
    logic           seg_hit;
    logic           pt_hit;
    logic           tri_hit;
    logic           rect_hit;
    logic           ge;
    logic           le;
    sht_pkg::diff_t d_y12;
    sht_pkg::diff_t d_x21;
    sht_pkg::diff_t d_x02;
    sht_pkg::diff_t d_y02;
    sht_pkg::diff_t d_y20;
    sht_pkg::diff_t d_cx2;
    sht_pkg::diff_t d_cy2;
    sht_pkg::edge_t den;
    sht_pkg::edge_t ea;
    sht_pkg::edge_t eb;
    sht_pkg::edge_t ec;
    sht_pkg::coord_t lx;
    sht_pkg::coord_t hx;
    sht_pkg::coord_t ly;
    sht_pkg::coord_t hy;

    pt_hit = (shape_i.vx0 == shape_i.click_x) && (shape_i.vy0 == shape_i.click_y);

    seg_box = (shape_i.click_x >= sht_pkg::cmin(shape_i.vx0, shape_i.vx1)) &&
              (shape_i.click_x <= sht_pkg::cmax(shape_i.vx0, shape_i.vx1)) &&
              (shape_i.click_y >= sht_pkg::cmin(shape_i.vy0, shape_i.vy1)) &&
              (shape_i.click_y <= sht_pkg::cmax(shape_i.vy0, shape_i.vy1));
    seg_hit = seg_box &&
              (sht_pkg::smul(sht_pkg::sdiff(shape_i.vy1, shape_i.vy0),
                             sht_pkg::sdiff(shape_i.click_x, shape_i.vx0)) ==
               sht_pkg::smul(sht_pkg::sdiff(shape_i.vx1, shape_i.vx0),
                             sht_pkg::sdiff(shape_i.click_y, shape_i.vy0)));

    // Edge functions of the triangle; the third is the remainder of the area.
    d_y12 = sht_pkg::sdiff(shape_i.vy1, shape_i.vy2);
    d_x21 = sht_pkg::sdiff(shape_i.vx2, shape_i.vx1);
    d_x02 = sht_pkg::sdiff(shape_i.vx0, shape_i.vx2);
    d_y02 = sht_pkg::sdiff(shape_i.vy0, shape_i.vy2);
    d_y20 = sht_pkg::sdiff(shape_i.vy2, shape_i.vy0);
    d_cx2 = sht_pkg::sdiff(shape_i.click_x, shape_i.vx2);
    d_cy2 = sht_pkg::sdiff(shape_i.click_y, shape_i.vy2);
    den = sht_pkg::edge_t'(sht_pkg::smul(d_y12, d_x02)) +
          sht_pkg::edge_t'(sht_pkg::smul(d_x21, d_y02));
    ea  = sht_pkg::edge_t'(sht_pkg::smul(d_y12, d_cx2)) +
          sht_pkg::edge_t'(sht_pkg::smul(d_x21, d_cy2));
    eb  = sht_pkg::edge_t'(sht_pkg::smul(d_y20, d_cx2)) +
          sht_pkg::edge_t'(sht_pkg::smul(d_x02, d_cy2));
    ec  = den - ea - eb;
    ge = !ea[sht_pkg::EDGE_W-1] && !eb[sht_pkg::EDGE_W-1] && !ec[sht_pkg::EDGE_W-1];
    le = (ea[sht_pkg::EDGE_W-1] || (ea == '0)) &&
         (eb[sht_pkg::EDGE_W-1] || (eb == '0)) &&
         (ec[sht_pkg::EDGE_W-1] || (ec == '0));
    tri_hit = (den != '0) && (ge || le);

    lx = sht_pkg::cmin(sht_pkg::cmin(shape_i.vx0, shape_i.vx1),
                       sht_pkg::cmin(shape_i.vx2, shape_i.vx3));
    hx = sht_pkg::cmax(sht_pkg::cmax(shape_i.vx0, shape_i.vx1),
                       sht_pkg::cmax(shape_i.vx2, shape_i.vx3));
    ly = sht_pkg::cmin(sht_pkg::cmin(shape_i.vy0, shape_i.vy1),
                       sht_pkg::cmin(shape_i.vy2, shape_i.vy3));
    hy = sht_pkg::cmax(sht_pkg::cmax(shape_i.vy0, shape_i.vy1),
                       sht_pkg::cmax(shape_i.vy2, shape_i.vy3));
    rect_hit = (shape_i.click_x >= lx) && (shape_i.click_x <= hx) &&
               (shape_i.click_y >= ly) && (shape_i.click_y <= hy);

    result_o.bad_kind    = 1'b0;
    result_o.last_result = shape_i.last_shape;
    unique case (shape_i.kind)
      sht_pkg::KIND_POINT: result_o.hit = pt_hit;
      sht_pkg::KIND_LINE:  result_o.hit = seg_hit;
      sht_pkg::KIND_TRI:   result_o.hit = tri_hit;
      sht_pkg::KIND_RECT:  result_o.hit = rect_hit;
    endcase
  end

endmodule

// File: hw/rtl/shape_hit_test_top.sv
// Top level of the shape hit test block: input register, hit test logic
// and result register with stream handshakes. Depends on sht_pkg, sht_eval.
//
// Each input item carries one shape (point, segment, triangle or rectangle,
// selected by in_tuser), its vertices and a click position in in_tdata, and
// in_tlast marking the final shape of the list for that click. For every
// item the block returns exactly one result item: out_tdata bit 0 is the
// hit flag, out_tuser flags an unknown shape kind, out_tlast copies in_tlast.
// The accepting edge loads the input register; the result register is loaded
// from it once the output register is free, raising out_tvalid. Throughput is
// one item per cycle while out_tready is high, set by the single pass of the
// test logic between those registers. The input register keeps accepting while
// a result waits in the output register; only when both hold an item and
// out_tready is low does in_tready drop. Results are never dropped or repeated
// under stalls. Reset empties both registers; the block has no other state.
module shape_hit_test_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // vx0, vy0, vx1, vy1, vx2, vy2, vx3, vy3, click_x, click_y
  input  logic [sht_pkg::TDATA_W-1:0] in_tdata,
  // mode
  input  logic [1:0]                  in_tuser,
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // hit, then zero fill
  output logic [sht_pkg::OUT_TDATA_W-1:0] out_tdata,
  // bad_kind
  output logic                        out_tuser,
  output logic                        out_tlast
);

  localparam int CW = sht_pkg::COORD_WIDTH;

  sht_pkg::shape_t  shape_in;
  sht_pkg::shape_t  shape_r;
  sht_pkg::result_t result;
  sht_pkg::result_t result_r;
  logic             s1_valid_r;
  logic             out_valid_r;
  logic             out_adv;

  always_comb begin
    shape_in.kind       = sht_pkg::kind_t'(in_tuser);
    shape_in.vx0        = in_tdata[0*CW +: CW];
    shape_in.vy0        = in_tdata[1*CW +: CW];
    shape_in.vx1        = in_tdata[2*CW +: CW];
    shape_in.vy1        = in_tdata[3*CW +: CW];
    shape_in.vx2        = in_tdata[4*CW +: CW];
    shape_in.vy2        = in_tdata[5*CW +: CW];
    shape_in.vx3        = in_tdata[6*CW +: CW];
    shape_in.vy3        = in_tdata[7*CW +: CW];
    shape_in.click_x    = in_tdata[8*CW +: CW];
    shape_in.click_y    = in_tdata[9*CW +: CW];
    shape_in.last_shape = in_tlast;
  end

  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      shape_r <= shape_in;
    end
    if (out_adv && s1_valid_r) begin
      result_r <= result;
    end
  end

  sht_eval u_eval (
    .shape_i  (shape_r),
    .result_o (result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(sht_pkg::OUT_TDATA_W-1){1'b0}}, result_r.hit};
  assign out_tuser  = result_r.bad_kind;
  assign out_tlast  = result_r.last_result;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for shape_hit_test_top: streams point, segment,
// triangle and rectangle hit tests and checks every result item against
// an exact in-bench predictor. Depends on sht_pkg and shape_hit_test_top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_SHAPES = 930;
  localparam int QUIET_TAIL    = 120;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 10;

  class hit_scoreboard;
    sht_pkg::result_t pending_hits[$];
    int               mismatches;

    function sht_pkg::result_t predict_hit(sht_pkg::shape_t s);
      longint           x[4];
      longint           y[4];
      longint           cx, cy, lx, hx, ly, hy;
      longint           den, ea, eb, ec;
      sht_pkg::result_t r;
      x[0] = s.vx0; y[0] = s.vy0;
      x[1] = s.vx1; y[1] = s.vy1;
      x[2] = s.vx2; y[2] = s.vy2;
      x[3] = s.vx3; y[3] = s.vy3;
      cx = s.click_x;
      cy = s.click_y;
      r.hit = 1'b0;
      r.bad_kind = 1'b0;
      r.last_result = s.last_shape;
      case (s.kind)
        sht_pkg::KIND_POINT: begin
          r.hit = (x[0] == cx) && (y[0] == cy);
        end
        sht_pkg::KIND_LINE: begin
          lx = (x[0] < x[1]) ? x[0] : x[1];
          hx = (x[0] > x[1]) ? x[0] : x[1];
          ly = (y[0] < y[1]) ? y[0] : y[1];
          hy = (y[0] > y[1]) ? y[0] : y[1];
          r.hit = (cx >= lx) && (cx <= hx) && (cy >= ly) && (cy <= hy) &&
                  ((y[1] - y[0]) * (cx - x[0]) == (x[1] - x[0]) * (cy - y[0]));
        end
        sht_pkg::KIND_TRI: begin
          den = (y[1] - y[2]) * (x[0] - x[2]) + (x[2] - x[1]) * (y[0] - y[2]);
          ea  = (y[1] - y[2]) * (cx - x[2]) + (x[2] - x[1]) * (cy - y[2]);
          eb  = (y[2] - y[0]) * (cx - x[2]) + (x[0] - x[2]) * (cy - y[2]);
          ec  = den - ea - eb;
          r.hit = (den != 0) && (((ea >= 0) && (eb >= 0) && (ec >= 0)) ||
                                 ((ea <= 0) && (eb <= 0) && (ec <= 0)));
        end
        sht_pkg::KIND_RECT: begin
          lx = x[0]; hx = x[0]; ly = y[0]; hy = y[0];
          for (int k = 1; k < 4; k++) begin
            if (x[k] < lx) lx = x[k];
            if (x[k] > hx) hx = x[k];
            if (y[k] < ly) ly = y[k];
            if (y[k] > hy) hy = y[k];
          end
          r.hit = (cx >= lx) && (cx <= hx) && (cy >= ly) && (cy <= hy);
        end
        default: begin
          r.bad_kind = 1'b1;
        end
      endcase
      return r;
    endfunction

    function void note_shape(sht_pkg::shape_t s);
      pending_hits.push_back(predict_hit(s));
    endfunction

    function void check_result(logic hit, logic bad_kind, logic last_result);
      sht_pkg::result_t want;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result item: hit=%0b bad_kind=%0b last=%0b",
                   hit, bad_kind, last_result);
        return;
      end
      want = pending_hits.pop_front();
      if (hit !== want.hit || bad_kind !== want.bad_kind ||
          last_result !== want.last_result) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result mismatch: expected hit=%0b bad_kind=%0b last=%0b, got %0b %0b %0b",
                   want.hit, want.bad_kind, want.last_result, hit, bad_kind, last_result);
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [sht_pkg::TDATA_W-1:0]     in_tdata = '0;
  logic [1:0]                      in_tuser = '0;
  logic                            in_tlast = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [sht_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            out_tlast;

  hit_scoreboard hits = new();
  bit            steady = 1'b0;
  int            ready_hold = 0;
  int            cycle_count = 0;

  shape_hit_test_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      ready_hold = $urandom_range(1, 8) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      hits.check_result(out_tdata[0], out_tuser, out_tlast);
  end

  function automatic sht_pkg::shape_t mk_shape(sht_pkg::kind_t k, int x0, int y0,
                                               int x1, int y1, int x2, int y2,
                                               int x3, int y3, int cx, int cy,
                                               bit last);
    sht_pkg::shape_t s;
    s.kind = k;
    s.vx0 = sht_pkg::coord_t'(x0); s.vy0 = sht_pkg::coord_t'(y0);
    s.vx1 = sht_pkg::coord_t'(x1); s.vy1 = sht_pkg::coord_t'(y1);
    s.vx2 = sht_pkg::coord_t'(x2); s.vy2 = sht_pkg::coord_t'(y2);
    s.vx3 = sht_pkg::coord_t'(x3); s.vy3 = sht_pkg::coord_t'(y3);
    s.click_x = sht_pkg::coord_t'(cx);
    s.click_y = sht_pkg::coord_t'(cy);
    s.last_shape = last;
    return s;
  endfunction

  function automatic int rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0)
      return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
    else if (pick <= 3)
      return int'(sht_pkg::coord_t'($urandom));
    else
      return int'($urandom_range(0, 40)) - 20;
  endfunction

  function automatic sht_pkg::shape_t random_shape();
    sht_pkg::shape_t s;
    int              base_x, base_y, dx, dy, reach, step, lx, hx, ly, hy;
    s = mk_shape(sht_pkg::kind_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 $urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) != 0) begin
      case (s.kind)
        sht_pkg::KIND_POINT: begin
          s.click_x = s.vx0;
          s.click_y = s.vy0;
        end
        sht_pkg::KIND_LINE: begin
          base_x = int'($urandom_range(0, 2000)) - 1000;
          base_y = int'($urandom_range(0, 2000)) - 1000;
          dx = int'($urandom_range(0, 10)) - 5;
          dy = int'($urandom_range(0, 10)) - 5;
          reach = $urandom_range(1, 6);
          step = $urandom_range(0, reach + 1);
          s.vx0 = sht_pkg::coord_t'(base_x);
          s.vy0 = sht_pkg::coord_t'(base_y);
          s.vx1 = sht_pkg::coord_t'(base_x + reach * dx);
          s.vy1 = sht_pkg::coord_t'(base_y + reach * dy);
          s.click_x = sht_pkg::coord_t'(base_x + step * dx +
                                        (($urandom_range(0, 3) == 0) ? 1 : 0));
          s.click_y = sht_pkg::coord_t'(base_y + step * dy);
        end
        sht_pkg::KIND_TRI: begin
          if ($urandom_range(0, 2) == 0) begin
            s.click_x = s.vx1;
            s.click_y = s.vy1;
          end else begin
            s.click_x = sht_pkg::coord_t'((int'(s.vx0) + int'(s.vx1) + int'(s.vx2)) / 3);
            s.click_y = sht_pkg::coord_t'((int'(s.vy0) + int'(s.vy1) + int'(s.vy2)) / 3);
          end
        end
        default: begin
          lx = int'(s.vx0) < int'(s.vx2) ? int'(s.vx0) : int'(s.vx2);
          hx = int'(s.vx0) < int'(s.vx2) ? int'(s.vx2) : int'(s.vx0);
          ly = int'(s.vy1) < int'(s.vy3) ? int'(s.vy1) : int'(s.vy3);
          hy = int'(s.vy1) < int'(s.vy3) ? int'(s.vy3) : int'(s.vy1);
          s.click_x = sht_pkg::coord_t'(lx + int'($urandom_range(0, hx - lx)));
          s.click_y = sht_pkg::coord_t'(ly + int'($urandom_range(0, hy - ly)));
        end
      endcase
    end
    return s;
  endfunction

  task automatic push_shape(sht_pkg::shape_t s);
    in_tvalid <= 1'b1;
    in_tdata  <= {s.click_y, s.click_x, s.vy3, s.vx3, s.vy2, s.vx2,
                  s.vy1, s.vx1, s.vy0, s.vx0};
    in_tuser  <= s.kind;
    in_tlast  <= s.last_shape;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    hits.note_shape(s);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    steady = 1'b1;
    push_shape(mk_shape(sht_pkg::KIND_POINT, -32768, 32767, 5, 5, 5, 5, 5, 5,
                        -32768, 32767, 0));
    push_shape(mk_shape(sht_pkg::KIND_POINT, 100, -7, 0, 0, 0, 0, 0, 0, 101, -7, 0));
    push_shape(mk_shape(sht_pkg::KIND_POINT, 32767, -32768, -1, -1, -1, -1, -1, -1,
                        32767, -32768, 1));
    push_shape(mk_shape(sht_pkg::KIND_LINE, 0, 0, 4, 2, 9, 9, 9, 9, 2, 1, 0));
    push_shape(mk_shape(sht_pkg::KIND_LINE, 0, 0, 4, 2, 9, 9, 9, 9, 3, 1, 0));
    push_shape(mk_shape(sht_pkg::KIND_LINE, 0, 0, 4, 2, 9, 9, 9, 9, 6, 3, 0));
    push_shape(mk_shape(sht_pkg::KIND_LINE, 5, 5, 5, 5, 0, 0, 0, 0, 5, 5, 0));
    push_shape(mk_shape(sht_pkg::KIND_LINE, 5, 5, 5, 5, 0, 0, 0, 0, 5, 6, 1));
    push_shape(mk_shape(sht_pkg::KIND_LINE, -32768, -32768, 32767, 32767, 0, 0, 0, 0,
                        0, 0, 0));
    push_shape(mk_shape(sht_pkg::KIND_LINE, -32768, -32768, 32767, 32767, 0, 0, 0, 0,
                        32767, -32768, 0));
    push_shape(mk_shape(sht_pkg::KIND_TRI, 0, 0, 10, 0, 0, 10, 32767, -32768, 2, 2, 0));
    push_shape(mk_shape(sht_pkg::KIND_TRI, 0, 0, 0, 10, 10, 0, -32768, 32767, 2, 2, 0));
    push_shape(mk_shape(sht_pkg::KIND_TRI, 0, 0, 10, 0, 0, 10, 0, 0, 10, 0, 0));
    push_shape(mk_shape(sht_pkg::KIND_TRI, 0, 0, 10, 0, 0, 10, 0, 0, 5, 5, 0));
    push_shape(mk_shape(sht_pkg::KIND_TRI, 0, 0, 10, 0, 0, 10, 0, 0, 8, 8, 0));
    push_shape(mk_shape(sht_pkg::KIND_TRI, 0, 0, 5, 5, 10, 10, 0, 0, 5, 5, 1));
    push_shape(mk_shape(sht_pkg::KIND_TRI, -32768, -32768, 32767, -32768, -32768, 32767,
                        0, 0, 32767, 32767, 0));
    push_shape(mk_shape(sht_pkg::KIND_TRI, -32768, -32768, 32767, -32768, -32768, 32767,
                        0, 0, 0, -1, 0));
    push_shape(mk_shape(sht_pkg::KIND_RECT, -3, -4, 7, -4, 7, 9, -3, 9, 7, 9, 0));
    push_shape(mk_shape(sht_pkg::KIND_RECT, -3, -4, 7, -4, 7, 9, -3, 9, 8, 0, 0));
    push_shape(mk_shape(sht_pkg::KIND_RECT, -3, -4, 7, -4, 7, 9, -3, 9, 0, 10, 0));
    push_shape(mk_shape(sht_pkg::KIND_RECT, -32768, -32768, 32767, -32768, 32767, 32767,
                        -32768, 32767, -32768, 32767, 0));
    push_shape(mk_shape(sht_pkg::KIND_RECT, 7, 9, -3, -4, -3, 9, 7, -4, 1, 1, 1));

    for (int i = 0; i < RANDOM_SHAPES; i++) begin
      steady = (i >= RANDOM_SHAPES - QUIET_TAIL) || ((i / 150) % 4 == 3);
      push_shape(random_shape());
    end
    steady = 1'b1;
    in_tvalid <= 1'b0;

    while (hits.pending_hits.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (hits.mismatches == 0 && hits.pending_hits.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
